@@ hdl/pjq_pkg.sv @@
// types, codes and helper functions shared by the job queue files
package pjq_pkg;

  typedef enum logic [3:0] {
    CMD_ADD       = 4'd0,
    CMD_DEL_TAG   = 4'd1,
    CMD_DEL_IDX   = 4'd2,
    CMD_PRI_TAG   = 4'd3,
    CMD_PRI_IDX   = 4'd4,
    CMD_READ_TAG  = 4'd5,
    CMD_READ_IDX  = 4'd6,
    CMD_POP       = 4'd7,
    CMD_CLEAR     = 4'd8,
    CMD_CRC       = 4'd9,
    CMD_NEXT_TAG  = 4'd10,
    CMD_RESET_TAG = 4'd11
  } pjq_cmd_e;

  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_MISS   = 2'd1,
    STAT_LOCKED = 2'd2,
    STAT_FULL   = 2'd3
  } pjq_status_e;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_START,
    CELL_SCAN,
    CELL_REMOVE,
    CELL_INSERT
  } pjq_cell_op_e;

  typedef enum logic [2:0] {
    FSM_IDLE,
    FSM_SCAN,
    FSM_EVAL,
    FSM_REMOVE,
    FSM_INSERT,
    FSM_DONE
  } pjq_fsm_e;

  typedef struct packed {
    logic signed [31:0] pri;
    logic signed [31:0] tag;
    logic [3:0]         zone;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic [15:0]        feed;
    logic [15:0]        spin;
    logic [15:0]        tool;
  } pjq_rec_t;

  typedef struct packed {
    pjq_cell_op_e       op;
    logic               by_tag;
    logic               strict;
    logic signed [31:0] tag;
    pjq_rec_t           ins_rec;
  } pjq_ctl_t;

  typedef struct packed {
    pjq_status_e status;
    pjq_rec_t    rec;
    logic [31:0] crc;
  } pjq_res_t;

  localparam logic signed [31:0] LOCK_PRI = 32'sh8000_0000;
  localparam logic [31:0]        CRC_POLY = 32'h0000_00D8;

  function automatic logic [31:0] crc_step(input logic [31:0] crc, input logic [31:0] tag);
    logic [31:0] r;
    r = {tag[7:0] ^ crc[31:24], 24'd0};
    for (int b = 0; b < 8; b++) begin
      r = r[31] ? ((r << 1) ^ CRC_POLY) : (r << 1);
    end
    return r ^ (crc << 8);
  endfunction

endpackage

@@ hdl/pjq_if.sv @@
// valid/ready channel interfaces for job commands and results
interface pjq_job_if;
  logic               valid;
  logic               ready;
  logic [3:0]         command;
  logic signed [31:0] priority_req;
  logic signed [31:0] tag;
  logic [5:0]         slot_index;
  logic [3:0]         zone;
  logic signed [31:0] x_offset;
  logic signed [31:0] y_offset;
  logic signed [31:0] z_offset;
  logic [15:0]        feed_override;
  logic [15:0]        spindle_override;
  logic [15:0]        tool_number;

  modport source (output valid, command, priority_req, tag, slot_index, zone, x_offset,
                  y_offset, z_offset, feed_override, spindle_override, tool_number,
                  input ready);
  modport sink (input valid, command, priority_req, tag, slot_index, zone, x_offset,
                y_offset, z_offset, feed_override, spindle_override, tool_number,
                output ready);
endinterface

interface pjq_res_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic [6:0]         entry_count;
  logic signed [31:0] priority_out;
  logic signed [31:0] tag_out;
  logic [3:0]         zone_out;
  logic signed [31:0] x_out;
  logic signed [31:0] y_out;
  logic signed [31:0] z_out;
  logic [15:0]        feed_out;
  logic [15:0]        spindle_out;
  logic [15:0]        tool_out;
  logic [31:0]        tag_crc;

  modport source (output valid, status, entry_count, priority_out, tag_out, zone_out, x_out,
                  y_out, z_out, feed_out, spindle_out, tool_out, tag_crc, input ready);
  modport sink (input valid, status, entry_count, priority_out, tag_out, zone_out, x_out,
                y_out, z_out, feed_out, spindle_out, tool_out, tag_crc, output ready);
endinterface

@@ hdl/pjq_cell.sv @@
// one queue slot: holds a record, shifts with its neighbors, passes scan data along
module pjq_cell #(
  parameter int IDX = 0,
  parameter int XW  = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pjq_pkg::pjq_ctl_t ctl_i,
  input  logic [XW-1:0]     count_i,
  input  logic [XW-1:0]     idx_i,
  input  pjq_pkg::pjq_rec_t left_rec_i,
  input  pjq_pkg::pjq_rec_t right_rec_i,
  input  logic              left_flag_i,
  output logic              flag_o,
  input  logic              left_fb_i,
  output logic              fb_o,
  input  pjq_pkg::pjq_rec_t right_ob_i,
  output pjq_pkg::pjq_rec_t ob_o,
  input  logic [31:0]       left_crc_i,
  output logic [31:0]       crc_o,
  output pjq_pkg::pjq_rec_t rec_o
);
  import pjq_pkg::*;

  localparam logic [XW-1:0] MY_IDX = XW'(IDX);

  pjq_rec_t    rec_q, rec_d, ob_q;
  logic        fb_q, ge_q;
  logic [31:0] crc_q;
  logic        valid, match, sel, ge;

  always_comb begin
    valid  = MY_IDX < count_i;
    match  = valid && (rec_q.tag == ctl_i.tag);
    sel    = ctl_i.by_tag ? (match && !fb_q) : (valid && (MY_IDX == idx_i));
    ge     = ctl_i.by_tag ? (fb_q || match) : (MY_IDX >= idx_i);
    flag_o = valid && ((ctl_i.strict && ge_q) ? (rec_q.pri < ctl_i.ins_rec.pri)
                                              : (rec_q.pri <= ctl_i.ins_rec.pri));
    fb_o   = fb_q || match;
    rec_d  = rec_q;
    case (ctl_i.op)
      CELL_INSERT: begin
        if (!flag_o) begin
          rec_d = left_flag_i ? ctl_i.ins_rec : left_rec_i;
        end
      end
      CELL_REMOVE: begin
        if (ge_q) begin
          rec_d = right_rec_i;
        end
      end
      default: rec_d = rec_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fb_q <= 1'b0;
      ge_q <= 1'b0;
    end else if (ctl_i.op == CELL_START) begin
      fb_q <= 1'b0;
    end else if (ctl_i.op == CELL_SCAN) begin
      fb_q <= left_fb_i;
      ge_q <= ge;
    end
  end

  always_ff @(posedge clk_i) begin
    rec_q <= rec_d;
    if (ctl_i.op == CELL_SCAN) begin
      ob_q  <= sel ? rec_q : right_ob_i;
      crc_q <= valid ? crc_step(left_crc_i, rec_q.tag) : left_crc_i;
    end
  end

  assign ob_o  = ob_q;
  assign crc_o = crc_q;
  assign rec_o = rec_q;

endmodule

@@ hdl/priority_job_queue_core.sv @@
// sorted job queue built from a chain of record cells
//
//  channel  direction  payload
//  job_i    in         command, priority, tag, index, zone, offsets, overrides, tool
//  res_o    out        status, entry_count, record fields, tag_crc
//
// a result is valid after a scan across the cell chain and an evaluation step: first-match
// flags ripple one cell a cycle, then the selected record and the tag crc ripple one cell
// a cycle; removal and reinsertion, where needed, follow in their own states
// one transaction at a time; job_i is ready only while idle, so a new transaction is taken
// only after the result of the last one is taken; the result is held until res_o is taken
// no clearing pass after reset
module priority_job_queue_core #(
  parameter int QUEUE_DEPTH = 64
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  pjq_job_if.sink  job_i,
  pjq_res_if.source res_o
);
  import pjq_pkg::*;

  localparam int CW  = $clog2(QUEUE_DEPTH + 1);
  localparam int XW  = CW + 6;
  localparam int SW  = $clog2(2 * QUEUE_DEPTH + 1);
  localparam logic [SW-1:0] SCAN_LAST = SW'(2 * QUEUE_DEPTH - 1);

  pjq_fsm_e           state_q, state_d;
  logic [SW-1:0]      scan_q, scan_d;
  logic [CW-1:0]      count_q, count_d;
  logic [31:0]        auto_q, auto_d;
  logic [3:0]         cmd_q;
  logic signed [31:0] pri_q, tag_q;
  logic [XW-1:0]      idx_q, count_ext;
  pjq_rec_t           ins_q, ins_d;
  pjq_res_t           res_q, res_d;
  pjq_ctl_t           ctl;
  logic               found, by_tag, is_pri;
  logic [CW+6:0]      count_wide;

  pjq_rec_t    rec_w [QUEUE_DEPTH];
  pjq_rec_t    ob_w  [QUEUE_DEPTH];
  logic        flag_w[QUEUE_DEPTH];
  logic        fb_w  [QUEUE_DEPTH];
  logic [31:0] crc_w [QUEUE_DEPTH];

  assign count_ext = XW'(count_q);
  assign by_tag = (cmd_q == CMD_DEL_TAG) || (cmd_q == CMD_PRI_TAG) || (cmd_q == CMD_READ_TAG);
  assign is_pri = (cmd_q == CMD_PRI_TAG) || (cmd_q == CMD_PRI_IDX);

  always_comb begin
    ctl.by_tag  = by_tag;
    ctl.strict  = is_pri;
    ctl.tag     = tag_q;
    ctl.ins_rec = ins_q;
    case (state_q)
      FSM_IDLE:   ctl.op = job_i.valid ? CELL_START : CELL_HOLD;
      FSM_SCAN:   ctl.op = CELL_SCAN;
      FSM_REMOVE: ctl.op = CELL_REMOVE;
      FSM_INSERT: ctl.op = CELL_INSERT;
      default:    ctl.op = CELL_HOLD;
    endcase
  end

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    pjq_rec_t    left_rec, right_rec, right_ob;
    logic        left_flag, left_fb;
    logic [31:0] left_crc;
    if (i == 0) begin : g_head
      assign left_rec  = '0;
      assign left_flag = 1'b1;
      assign left_fb   = 1'b0;
      assign left_crc  = '0;
    end else begin : g_body
      assign left_rec  = rec_w[i-1];
      assign left_flag = flag_w[i-1];
      assign left_fb   = fb_w[i-1];
      assign left_crc  = crc_w[i-1];
    end
    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign right_rec = rec_w[i];
      assign right_ob  = '0;
    end else begin : g_mid
      assign right_rec = rec_w[i+1];
      assign right_ob  = ob_w[i+1];
    end
    pjq_cell #(.IDX(i), .XW(XW)) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctl_i       (ctl),
      .count_i     (count_ext),
      .idx_i       (idx_q),
      .left_rec_i  (left_rec),
      .right_rec_i (right_rec),
      .left_flag_i (left_flag),
      .flag_o      (flag_w[i]),
      .left_fb_i   (left_fb),
      .fb_o        (fb_w[i]),
      .right_ob_i  (right_ob),
      .ob_o        (ob_w[i]),
      .left_crc_i  (left_crc),
      .crc_o       (crc_w[i]),
      .rec_o       (rec_w[i])
    );
  end

  assign found = by_tag ? fb_w[QUEUE_DEPTH-1] : (idx_q < count_ext);

  always_comb begin
    state_d = state_q;
    scan_d  = scan_q;
    count_d = count_q;
    auto_d  = auto_q;
    ins_d   = ins_q;
    res_d   = res_q;
    case (state_q)
      FSM_IDLE: begin
        if (job_i.valid) begin
          state_d    = FSM_SCAN;
          scan_d     = '0;
          ins_d.pri  = job_i.priority_req;
          ins_d.tag  = job_i.tag;
          ins_d.zone = job_i.zone;
          ins_d.x    = (job_i.zone == 4'd0) ? job_i.x_offset : '0;
          ins_d.y    = (job_i.zone == 4'd0) ? job_i.y_offset : '0;
          ins_d.z    = (job_i.zone == 4'd0) ? job_i.z_offset : '0;
          ins_d.feed = job_i.feed_override;
          ins_d.spin = job_i.spindle_override;
          ins_d.tool = job_i.tool_number;
        end
      end
      FSM_SCAN: begin
        scan_d = scan_q + SW'(1);
        if (scan_q == SCAN_LAST) begin
          state_d = FSM_EVAL;
        end
      end
      FSM_EVAL: begin
        res_d   = '0;
        state_d = FSM_DONE;
        case (cmd_q)
          CMD_ADD: begin
            if (count_q >= CW'(QUEUE_DEPTH)) begin
              res_d.status = STAT_FULL;
            end else begin
              state_d = FSM_INSERT;
            end
          end
          CMD_DEL_TAG, CMD_DEL_IDX, CMD_PRI_TAG, CMD_PRI_IDX: begin
            if (!found) begin
              res_d.status = STAT_MISS;
            end else if (ob_w[0].pri == LOCK_PRI) begin
              res_d.status = STAT_LOCKED;
            end else begin
              state_d   = FSM_REMOVE;
              ins_d     = ob_w[0];
              ins_d.pri = pri_q;
            end
          end
          CMD_READ_TAG, CMD_READ_IDX: begin
            if (!found) begin
              res_d.status = STAT_MISS;
            end else begin
              res_d.rec = ob_w[0];
            end
          end
          CMD_POP: begin
            if (!found) begin
              res_d.status = STAT_MISS;
            end else begin
              res_d.rec = ob_w[0];
              state_d   = FSM_REMOVE;
            end
          end
          CMD_CLEAR:     count_d = '0;
          CMD_CRC:       res_d.crc = crc_w[QUEUE_DEPTH-1];
          CMD_NEXT_TAG: begin
            res_d.rec.tag = auto_q;
            auto_d        = auto_q + 32'd1;
          end
          CMD_RESET_TAG: auto_d = tag_q;
          default:       res_d.status = STAT_MISS;
        endcase
      end
      FSM_REMOVE: begin
        count_d = count_q - CW'(1);
        state_d = is_pri ? FSM_INSERT : FSM_DONE;
      end
      FSM_INSERT: begin
        count_d = count_q + CW'(1);
        state_d = FSM_DONE;
      end
      FSM_DONE: begin
        if (res_o.ready) begin
          state_d = FSM_IDLE;
        end
      end
      default: state_d = FSM_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FSM_IDLE;
      scan_q  <= '0;
      count_q <= '0;
      auto_q  <= '0;
    end else begin
      state_q <= state_d;
      scan_q  <= scan_d;
      count_q <= count_d;
      auto_q  <= auto_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    ins_q <= ins_d;
    if (state_q == FSM_IDLE && job_i.valid) begin
      cmd_q <= job_i.command;
      pri_q <= job_i.priority_req;
      tag_q <= job_i.tag;
      idx_q <= (job_i.command == CMD_POP) ? '0 : XW'(job_i.slot_index);
    end
  end

  assign count_wide = (CW + 7)'(count_q);

  assign job_i.ready        = (state_q == FSM_IDLE);
  assign res_o.valid        = (state_q == FSM_DONE);
  assign res_o.status       = res_q.status;
  assign res_o.entry_count  = count_wide[6:0];
  assign res_o.priority_out = res_q.rec.pri;
  assign res_o.tag_out      = res_q.rec.tag;
  assign res_o.zone_out     = res_q.rec.zone;
  assign res_o.x_out        = res_q.rec.x;
  assign res_o.y_out        = res_q.rec.y;
  assign res_o.z_out        = res_q.rec.z;
  assign res_o.feed_out     = res_q.rec.feed;
  assign res_o.spindle_out  = res_q.rec.spin;
  assign res_o.tool_out     = res_q.rec.tool;
  assign res_o.tag_crc      = res_q.crc;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(QUEUE_DEPTH))
    else $error("entry count beyond queue depth");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> !job_i.ready)
    else $error("new transaction taken while a result is pending");

  a_insert_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == FSM_INSERT |-> $past(state_q) == FSM_EVAL || $past(state_q) == FSM_REMOVE)
    else $error("insert without evaluation or removal");

endmodule
